// ===== src/eptq_pkg.sv =====
// eptq_pkg: types and codes shared by the expiring priority task queue
// no dependencies
`default_nettype none
package eptq_pkg;
  typedef enum logic [2:0] {
    EV_QUEUED   = 3'd0,
    EV_EXPIRED  = 3'd1,
    EV_REJECTED = 3'd2,
    EV_TAKEN    = 3'd3,
    EV_EMPTY    = 3'd4
  } event_t;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_TAKE   = 1'b1;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] instr;
    logic [31:0] limit;
    logic [31:0] arrival;
  } entry_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] now;
    logic [15:0] task_id;
    logic [31:0] instr_count;
    logic [31:0] exec_limit;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] out_id;
    logic [31:0] out_instr;
    logic [31:0] out_limit;
    logic [31:0] out_arrival;
    logic [5:0]  waiting_count;
    logic [31:0] longest_wait;
    logic        last;
  } out_item_t;

  // per-cycle command to each cell of the chain
  typedef enum logic [1:0] {
    CMD_HOLD  = 2'd0,
    CMD_ROT   = 2'd1,
    CMD_SHIFT = 2'd2,
    CMD_LOAD  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_WALK   = 3'd1,
    ST_INSERT = 3'd2,
    ST_OUT    = 3'd3
  } state_t;
endpackage
`default_nettype wire

// ===== src/eptq_if.sv =====
// eptq_if: valid/ready channel carrying one item
// depends on nothing; payload type given as a parameter
`default_nettype none
interface eptq_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/eptq_cell.sv =====
// eptq_cell: one slot of the queue chain
// depends on eptq_pkg
`default_nettype none
module eptq_cell
  import eptq_pkg::*;
(
  input  wire logic   clk,
  input  wire cmd_t   cmd,
  input  wire entry_t from_next,
  input  wire entry_t from_prev,
  input  wire entry_t load_in,
  output entry_t      entry
);
  // rotate moves entries towards the head, shift moves them towards the tail,
  // load takes the shared load bus
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_ROT:   entry <= from_next;
      CMD_SHIFT: entry <= from_prev;
      CMD_LOAD:  entry <= load_in;
      default:   entry <= entry;
    endcase
  end
endmodule
`default_nettype wire

// ===== src/expiring_priority_task_queue_top.sv =====
// expiring_priority_task_queue_top: sorted task queue with expiry as a chain of cells
// depends on eptq_pkg, eptq_if, eptq_cell
//
//  channel | dir | payload
//  in_ch   | in  | kind, now, task_id, instr_count, exec_limit
//  out_ch  | out | event_res, out_id, out_instr, out_limit, out_arrival,
//          |     | waiting_count, longest_wait, last
//
// an insert checks the head cell once per queued entry, moving kept entries to
// the back of the occupied run and closing up dropped ones, then settles the
// count and opens the slot for the new task, or rejects it when the queue is full.
// reset clears the occupancy and control; slot contents stay undefined.
// a stalled result holds the walk until it is taken.
`default_nettype none
module expiring_priority_task_queue_top
  import eptq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input wire logic clk,
  input wire logic rst,
  eptq_if.sink     in_ch,
  eptq_if.source   out_ch
);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t   cmds [QUEUE_DEPTH];
  entry_t cells [QUEUE_DEPTH];
  entry_t ins_entry;
  entry_t load_bus;

  state_t         state, state_next;
  in_item_t       req;
  logic [CW-1:0]  occ, occ_next;
  logic [CW-1:0]  cnt, cnt_next;     // entries still to walk
  logic [CW-1:0]  kept, kept_next;
  logic [CW-1:0]  pos, pos_next;     // walked entries placed ahead of new task
  logic           found, found_next;
  logic [31:0]    longest, longest_next;
  out_item_t      res, res_next;
  logic           res_valid, res_valid_next;

  // chain of cells; cell 0 is the head
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    entry_t nxt, prv;
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign nxt = cells[0];
    end else begin : g_mid
      assign nxt = cells[g + 1];
    end
    if (g == 0) begin : g_first
      assign prv = ins_entry;
    end else begin : g_rest
      assign prv = cells[g - 1];
    end
    eptq_cell u_cell (.clk(clk), .cmd(cmds[g]), .from_next(nxt), .from_prev(prv),
                      .load_in(load_bus), .entry(cells[g]));
  end

  logic [31:0] wait_t;
  assign wait_t = req.now - cells[0].arrival;

  always_comb begin
    ins_entry.id      = req.task_id;
    ins_entry.instr   = req.instr_count;
    ins_entry.limit   = req.exec_limit;
    ins_entry.arrival = req.now;
  end

  // load bus: the head entry while walking, the new task when inserting
  assign load_bus = (state == ST_INSERT) ? ins_entry : cells[0];

  // registered state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occ       <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      occ       <= occ_next;
      res_valid <= res_valid_next;
    end
    if (in_ch.valid && in_ch.ready) req <= in_ch.data;
    cnt     <= cnt_next;
    kept    <= kept_next;
    pos     <= pos_next;
    found   <= found_next;
    longest <= longest_next;
    res     <= res_next;
  end

  assign in_ch.ready  = (state == ST_IDLE) && !res_valid;
  assign out_ch.valid = res_valid;
  assign out_ch.data  = res;

  // sequencer
  always_comb begin
    logic [31:0]   lw;
    logic          out_free;
    logic [CW-1:0] span;
    lw             = '0;
    out_free       = !res_valid || out_ch.ready;
    span           = cnt + kept;
    state_next     = state;
    occ_next       = occ;
    cnt_next       = cnt;
    kept_next      = kept;
    pos_next       = pos;
    found_next     = found;
    longest_next   = longest;
    res_next       = res;
    res_valid_next = res_valid && !out_ch.ready;
    for (int i = 0; i < QUEUE_DEPTH; i++) cmds[i] = CMD_HOLD;
    case (state)
      ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          if (in_ch.data.kind == KIND_TAKE) begin
            state_next = ST_OUT;
          end else begin
            cnt_next     = occ;
            kept_next    = '0;
            pos_next     = '0;
            found_next   = 1'b0;
            longest_next = '0;
            state_next   = ST_WALK;
          end
        end
      end
      ST_OUT: begin
        // take: head leaves, rest moves up; an empty queue gives an empty result
        res_next = '0;
        res_next.last = 1'b1;
        if (occ == '0) begin
          res_next.event_res = EV_EMPTY;
        end else begin
          res_next.event_res     = EV_TAKEN;
          res_next.out_id        = cells[0].id;
          res_next.out_instr     = cells[0].instr;
          res_next.out_limit     = cells[0].limit;
          res_next.out_arrival   = cells[0].arrival;
          res_next.waiting_count = 6'(occ - 1'b1);
          occ_next = occ - 1'b1;
          for (int i = 0; i < QUEUE_DEPTH; i++)
            if (CW'(i) + 1'b1 < occ) cmds[i] = CMD_ROT;
        end
        res_valid_next = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_WALK: begin
        if (cnt == '0) begin
          // kept entries now sit in order at the head
          occ_next   = kept;
          state_next = ST_INSERT;
        end else if (out_free) begin
          lw = (wait_t > longest) ? wait_t : longest;
          longest_next = lw;
          cnt_next     = cnt - 1'b1;
          if (cells[0].limit < wait_t) begin
            // drop: the occupied run closes up over the head
            for (int i = 0; i < QUEUE_DEPTH; i++)
              if (CW'(i) + 1'b1 < span) cmds[i] = CMD_ROT;
            res_next.event_res     = EV_EXPIRED;
            res_next.out_id        = cells[0].id;
            res_next.out_instr     = cells[0].instr;
            res_next.out_limit     = cells[0].limit;
            res_next.out_arrival   = cells[0].arrival;
            res_next.waiting_count = 6'(kept + cnt - 1'b1);
            res_next.longest_wait  = lw;
            res_next.last          = 1'b0;
            res_valid_next         = 1'b1;
          end else begin
            // keep: the head moves to the back of the occupied run
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
              if (CW'(i) + 1'b1 < span) cmds[i] = CMD_ROT;
              else if (CW'(i) + 1'b1 == span) cmds[i] = CMD_LOAD;
            end
            kept_next = kept + 1'b1;
            if (!found && !(cells[0].limit > req.exec_limit)) pos_next = pos + 1'b1;
            else found_next = 1'b1;
          end
        end
      end
      ST_INSERT: begin
        // open the slot at pos and load the new task into it, or reject it when full
        if (out_free) begin
          if (occ >= CW'(QUEUE_DEPTH)) begin
            res_next = '0;
            res_next.event_res     = EV_REJECTED;
            res_next.out_id        = req.task_id;
            res_next.waiting_count = 6'(occ);
            res_next.longest_wait  = longest;
            res_next.last          = 1'b1;
            res_valid_next         = 1'b1;
            state_next             = ST_IDLE;
          end else begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
              if (CW'(i) == pos) cmds[i] = CMD_LOAD;
              else if (CW'(i) > pos && CW'(i) <= occ) cmds[i] = CMD_SHIFT;
            end
            res_next = '0;
            res_next.event_res     = EV_QUEUED;
            res_next.out_id        = req.task_id;
            res_next.waiting_count = 6'(occ + 1'b1);
            res_next.longest_wait  = longest;
            res_next.last          = 1'b1;
            res_valid_next         = 1'b1;
            occ_next               = occ + 1'b1;
            state_next             = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== src/eptq_checker.sv =====
// eptq_checker: port-level checks for the task queue
// depends on eptq_pkg; bound to expiring_priority_task_queue_top
`default_nettype none
module eptq_checker
  import eptq_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.waiting_count <= 6'd63)
    else $error("waiting count out of range");
  a_take_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.event_res == EV_TAKEN || out_data.event_res == EV_EMPTY)
    |-> out_data.last && out_data.longest_wait == '0)
    else $error("take result malformed");
  a_expired_notlast: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.event_res == EV_EXPIRED |-> !out_data.last)
    else $error("drop marked last");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");
endmodule

bind expiring_priority_task_queue_top eptq_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
`default_nettype wire
